// ===== design/pcs_pkg.sv =====
// ----------------------------------------------------------------------------
// pcs_pkg
// shared types and constants of the preference cursor selector
// ----------------------------------------------------------------------------
package pcs_pkg;

  localparam int AgentCountDef = 64;
  localparam int ListDepthDef  = 64;

  localparam int IdW     = 6;
  localparam int LenW    = 7;
  localparam int CostW   = 7;
  localparam int OwnW    = 18;
  localparam int OtherW  = 7;
  localparam int InDataW = 40;
  localparam int OpW     = 3;
  localparam int OutW    = 32;
  localparam int AddrW   = 4;

  localparam logic [CostW-1:0] CostMax     = 7'd127;
  localparam logic [LenW-1:0]  SkipLimRst  = 7'd5;
  localparam logic [6:0]       EndCode     = 7'h7F;

  typedef enum logic [2:0] {
    OP_OWN_ENTRY   = 3'd0,
    OP_OTHER_ENTRY = 3'd1,
    OP_OWN_LEN     = 3'd2,
    OP_OTHER_LEN   = 3'd3,
    OP_CANDIDATE   = 3'd4,
    OP_TAKEN       = 3'd5,
    OP_BEGIN       = 3'd6,
    OP_ADVANCE     = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    MODE_SEQ  = 2'd0,
    MODE_SKIP = 2'd1,
    MODE_BEST = 2'd2,
    MODE_ALT  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_SELF_ID   = 2'd0,
    REG_MODE      = 2'd1,
    REG_SKIP_LIM  = 2'd2,
    REG_NONE      = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SKIP,
    ST_BEST,
    ST_OWN_RD,
    ST_OWN_GOT,
    ST_COST_CNT,
    ST_COST_WALK,
    ST_COST_DONE,
    ST_FINAL,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    RET_SKIP,
    RET_BEST,
    RET_FINAL
  } ret_e;

endpackage

// ===== design/preference_cursor_selector.sv =====
// ----------------------------------------------------------------------------
// preference_cursor_selector
// cursor over a tied preference list with sequential, skip and best advance
// ----------------------------------------------------------------------------
// One transfer in, one transfer out. An item with the cursor on an entry
// counts the cost of that entry again, reading at most that agent's list
// length from its list. Skip advance counts the cost of each own entry
// passed; best advance does the same for every untaken own entry and reads
// but does not count a taken one. The run time is set by the single read
// port of the other-side list memory, walked one entry a cycle by the shared
// cost counter. After reset a clearing pass over all AGENT_COUNT entries
// zeroes the other-side length memory; s_axis_tready stays low meanwhile.
// The next item is accepted once the sequencer is idle and the result
// register is free or being taken.
// ----------------------------------------------------------------------------
module preference_cursor_selector #(
  parameter int AGENT_COUNT = pcs_pkg::AgentCountDef,
  parameter int LIST_DEPTH  = pcs_pkg::ListDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // slave side
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // owner, slot, entry_id, tie_group, tie_position, group_end, list_length,
  // member (lowest bit up), one zero pad bit
  input  logic [pcs_pkg::InDataW-1:0] s_axis_tdata_i,
  // operation
  input  logic [pcs_pkg::OpW-1:0]     s_axis_tuser_i,
  // master side
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // cursor_group, cursor_position, at_end, cursor_agent, entry_cost
  // (lowest bit up), four zero pad bits
  output logic [pcs_pkg::OutW-1:0]    m_axis_tdata_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pcs_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int AW  = (AGENT_COUNT > 1) ? $clog2(AGENT_COUNT) : 1;
  localparam int LiW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW  = $clog2(LIST_DEPTH + 1);
  localparam int OAW = $clog2(AGENT_COUNT * LIST_DEPTH);

  // input fields
  logic [5:0] owner, slot, entry_id, tie_group, tie_pos;
  logic       group_end, member;
  logic [6:0] list_len;
  pcs_pkg::op_e op;

  assign owner     = s_axis_tdata_i[5:0];
  assign slot      = s_axis_tdata_i[11:6];
  assign entry_id  = s_axis_tdata_i[17:12];
  assign tie_group = s_axis_tdata_i[23:18];
  assign tie_pos   = s_axis_tdata_i[29:24];
  assign group_end = s_axis_tdata_i[30];
  assign list_len  = s_axis_tdata_i[37:31];
  assign member    = s_axis_tdata_i[38];
  assign op        = pcs_pkg::op_e'(s_axis_tuser_i);

  // length saturated at the list depth
  logic [CW-1:0] len_sat;
  assign len_sat = (32'(list_len) > LIST_DEPTH) ? CW'(LIST_DEPTH) : CW'(list_len);

  // configuration registers
  logic [5:0] self_id_q;
  logic [1:0] mode_q;
  logic [6:0] skip_lim_q;
  pcs_pkg::reg_e reg_sel;
  logic cfg_wr;

  assign reg_sel = pcs_pkg::reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_id_q  <= '0;
      mode_q     <= '0;
      skip_lim_q <= pcs_pkg::SkipLimRst;
    end else if (cfg_wr) begin
      case (reg_sel)
        pcs_pkg::REG_SELF_ID:  self_id_q  <= pwdata[5:0];
        pcs_pkg::REG_MODE:     mode_q     <= pwdata[1:0];
        pcs_pkg::REG_SKIP_LIM: skip_lim_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      pcs_pkg::REG_SELF_ID:  prdata = {26'd0, self_id_q};
      pcs_pkg::REG_MODE:     prdata = {30'd0, mode_q};
      pcs_pkg::REG_SKIP_LIM: prdata = {25'd0, skip_lim_q};
      default:               prdata = '0;
    endcase
  end

  // sequencer state
  pcs_pkg::state_e st_q, st_d;
  pcs_pkg::ret_e   ret_q, ret_d;
  logic [CW-1:0]   own_cnt_q, own_cnt_d;
  logic [CW-1:0]   idx_q, idx_d;        // cursor index
  logic            cv_q, cv_d;          // cursor valid
  logic [CW-1:0]   oi_q, oi_d;          // own list index being read
  logic [CW-1:0]   bidx_q, bidx_d;      // best index so far
  logic [6:0]      bcost_q, bcost_d;
  logic            have_q, have_d;
  logic [5:0]      cagent_q, cagent_d;  // agent whose cost is counted
  logic [CW-1:0]   ci_q, ci_d;          // other list issue index
  logic            pend_q, pend_d;      // other list read in flight
  logic [6:0]      cost_q, cost_d;
  logic            found_q, found_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic [63:0]     cand_q, cand_d, taken_q, taken_d;
  logic            mv_q, mv_d;
  logic [pcs_pkg::OutW-1:0] out_q, out_d;

  logic s_xfer;
  assign s_axis_tready_o = (st_q == pcs_pkg::ST_IDLE) && (!mv_q || m_axis_tready_i);
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = mv_q;
  assign m_axis_tdata_o  = out_q;

  // memories
  logic [pcs_pkg::OwnW-1:0]   own_mem [LIST_DEPTH];
  logic [pcs_pkg::OtherW-1:0] oth_mem [AGENT_COUNT*LIST_DEPTH];
  logic [CW-1:0]              cnt_mem [AGENT_COUNT];
  logic [pcs_pkg::OwnW-1:0]   own_rd_q;
  logic [pcs_pkg::OtherW-1:0] oth_rd_q;
  logic [CW-1:0]              cnt_rd_q;

  logic own_we, oth_we, cnt_we;
  logic [OAW-1:0] oth_waddr, oth_raddr;
  logic [AW-1:0]  cnt_waddr;
  logic [CW-1:0]  cnt_wdata;

  assign own_we    = s_xfer && (op == pcs_pkg::OP_OWN_ENTRY) && (32'(slot) < LIST_DEPTH);
  assign oth_we    = s_xfer && (op == pcs_pkg::OP_OTHER_ENTRY) && (32'(slot) < LIST_DEPTH)
                     && (32'(owner) < AGENT_COUNT);
  assign oth_waddr = OAW'(32'(AW'(owner)) * LIST_DEPTH + 32'(slot));
  assign oth_raddr = OAW'(32'(AW'(cagent_q)) * LIST_DEPTH + 32'(ci_q));
  assign cnt_we    = (st_q == pcs_pkg::ST_CLEAR) ||
                     (s_xfer && (op == pcs_pkg::OP_OTHER_LEN) && (32'(owner) < AGENT_COUNT));
  assign cnt_waddr = (st_q == pcs_pkg::ST_CLEAR) ? clr_q : AW'(owner);
  assign cnt_wdata = (st_q == pcs_pkg::ST_CLEAR) ? '0 : len_sat;

  always_ff @(posedge clk_i) begin
    if (own_we) begin
      own_mem[LiW'(slot)] <= {tie_pos, tie_group, entry_id};
    end
    own_rd_q <= own_mem[oi_q[LiW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (oth_we) begin
      oth_mem[oth_waddr] <= {group_end, entry_id};
    end
    oth_rd_q <= oth_mem[oth_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rd_q <= cnt_mem[AW'(cagent_q)];
  end

  // cost walk evaluation of the entry just read
  logic [5:0] ev_id;
  logic       ev_gend, ev_found, issue;
  logic [6:0] ev_cost;
  assign ev_id    = oth_rd_q[5:0];
  assign ev_gend  = oth_rd_q[6];
  assign ev_found = found_q || (ev_id == self_id_q);
  assign ev_cost  = (!cand_q[ev_id] && cost_q < pcs_pkg::CostMax) ? cost_q + 7'd1 : cost_q;
  assign issue    = ci_q < cnt_rd_q;

  logic [CW-1:0] nidx;
  logic          clamp_cv;
  assign nidx     = idx_q + CW'(1);
  assign clamp_cv = cv_q && (idx_q < own_cnt_q);

  always_comb begin
    st_d      = st_q;
    ret_d     = ret_q;
    own_cnt_d = own_cnt_q;
    idx_d     = idx_q;
    cv_d      = cv_q;
    oi_d      = oi_q;
    bidx_d    = bidx_q;
    bcost_d   = bcost_q;
    have_d    = have_q;
    cagent_d  = cagent_q;
    ci_d      = ci_q;
    pend_d    = pend_q;
    cost_d    = cost_q;
    found_d   = found_q;
    clr_d     = clr_q;
    cand_d    = cand_q;
    taken_d   = taken_q;
    mv_d      = mv_q && !m_axis_tready_i;
    out_d     = out_q;

    case (st_q)
      pcs_pkg::ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(AGENT_COUNT - 1)) begin
          st_d = pcs_pkg::ST_IDLE;
        end
      end
      pcs_pkg::ST_IDLE: begin
        if (s_xfer) begin
          st_d = pcs_pkg::ST_FINAL;
          case (op)
            pcs_pkg::OP_OWN_LEN:   own_cnt_d = len_sat;
            pcs_pkg::OP_CANDIDATE: cand_d[entry_id] = member;
            pcs_pkg::OP_TAKEN:     taken_d[entry_id] = member;
            pcs_pkg::OP_BEGIN: begin
              idx_d = '0;
              cv_d  = own_cnt_q != '0;
            end
            pcs_pkg::OP_ADVANCE: begin
              cv_d = clamp_cv;
              case (pcs_pkg::mode_e'(mode_q))
                pcs_pkg::MODE_SKIP: st_d = pcs_pkg::ST_SKIP;
                pcs_pkg::MODE_BEST: begin
                  oi_d   = '0;
                  have_d = 1'b0;
                  st_d   = pcs_pkg::ST_BEST;
                end
                default: begin
                  // single step
                  if (clamp_cv) begin
                    idx_d = nidx;
                    cv_d  = nidx < own_cnt_q;
                  end
                end
              endcase
            end
            default: ;
          endcase
        end
      end
      pcs_pkg::ST_SKIP: begin
        if (!cv_q) begin
          st_d = pcs_pkg::ST_FINAL;
        end else begin
          idx_d = nidx;
          if (nidx >= own_cnt_q) begin
            cv_d = 1'b0;
            st_d = pcs_pkg::ST_FINAL;
          end else begin
            oi_d  = nidx;
            ret_d = pcs_pkg::RET_SKIP;
            st_d  = pcs_pkg::ST_OWN_RD;
          end
        end
      end
      pcs_pkg::ST_BEST: begin
        if (oi_q < own_cnt_q) begin
          ret_d = pcs_pkg::RET_BEST;
          st_d  = pcs_pkg::ST_OWN_RD;
        end else begin
          cv_d  = have_q;
          idx_d = have_q ? bidx_q : '0;
          st_d  = pcs_pkg::ST_FINAL;
        end
      end
      pcs_pkg::ST_OWN_RD: st_d = pcs_pkg::ST_OWN_GOT;
      pcs_pkg::ST_OWN_GOT: begin
        if (ret_q == pcs_pkg::RET_BEST && taken_q[own_rd_q[5:0]]) begin
          oi_d = oi_q + CW'(1);
          st_d = pcs_pkg::ST_BEST;
        end else begin
          cagent_d = own_rd_q[5:0];
          st_d     = pcs_pkg::ST_COST_CNT;
        end
      end
      pcs_pkg::ST_COST_CNT: begin
        ci_d    = '0;
        pend_d  = 1'b0;
        cost_d  = '0;
        found_d = 1'b0;
        st_d    = (32'(cagent_q) < AGENT_COUNT) ? pcs_pkg::ST_COST_WALK : pcs_pkg::ST_COST_DONE;
      end
      pcs_pkg::ST_COST_WALK: begin
        ci_d   = issue ? ci_q + CW'(1) : ci_q;
        pend_d = issue;
        if (pend_q) begin
          cost_d  = ev_cost;
          found_d = ev_found;
          if (ev_gend && ev_found) begin
            st_d = pcs_pkg::ST_COST_DONE;
          end
        end else if (!issue) begin
          st_d = pcs_pkg::ST_COST_DONE;
        end
      end
      pcs_pkg::ST_COST_DONE: begin
        case (ret_q)
          pcs_pkg::RET_SKIP: begin
            st_d = (cost_q <= skip_lim_q) ? pcs_pkg::ST_FINAL : pcs_pkg::ST_SKIP;
          end
          pcs_pkg::RET_BEST: begin
            if (!have_q || cost_q < bcost_q) begin
              have_d  = 1'b1;
              bcost_d = cost_q;
              bidx_d  = oi_q;
            end
            oi_d = oi_q + CW'(1);
            st_d = pcs_pkg::ST_BEST;
          end
          default: st_d = pcs_pkg::ST_OUT;
        endcase
      end
      pcs_pkg::ST_FINAL: begin
        if (clamp_cv) begin
          oi_d  = idx_q;
          ret_d = pcs_pkg::RET_FINAL;
          st_d  = pcs_pkg::ST_OWN_RD;
        end else begin
          cv_d = 1'b0;
          st_d = pcs_pkg::ST_OUT;
        end
      end
      pcs_pkg::ST_OUT: begin
        if (!mv_q || m_axis_tready_i) begin
          mv_d = 1'b1;
          if (cv_q) begin
            out_d = {4'd0, cost_q, own_rd_q[5:0], 1'b0,
                     1'b0, own_rd_q[17:12], 1'b0, own_rd_q[11:6]};
          end else begin
            out_d = {4'd0, 7'd0, 6'd0, 1'b1,
                     (mode_q == 2'(pcs_pkg::MODE_BEST)) ? pcs_pkg::EndCode : 7'd0,
                     pcs_pkg::EndCode};
          end
          st_d = pcs_pkg::ST_IDLE;
        end
      end
      default: st_d = pcs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= pcs_pkg::ST_CLEAR;
      ret_q     <= pcs_pkg::RET_FINAL;
      own_cnt_q <= '0;
      idx_q     <= '0;
      cv_q      <= 1'b0;
      oi_q      <= '0;
      have_q    <= 1'b0;
      pend_q    <= 1'b0;
      clr_q     <= '0;
      cand_q    <= '0;
      taken_q   <= '0;
      mv_q      <= 1'b0;
    end else begin
      st_q      <= st_d;
      ret_q     <= ret_d;
      own_cnt_q <= own_cnt_d;
      idx_q     <= idx_d;
      cv_q      <= cv_d;
      oi_q      <= oi_d;
      have_q    <= have_d;
      pend_q    <= pend_d;
      clr_q     <= clr_d;
      cand_q    <= cand_d;
      taken_q   <= taken_d;
      mv_q      <= mv_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    bidx_q   <= bidx_d;
    bcost_q  <= bcost_d;
    cagent_q <= cagent_d;
    ci_q     <= ci_d;
    cost_q   <= cost_d;
    found_q  <= found_d;
    out_q    <= out_d;
  end

endmodule

// ===== design/pcs_checker.sv =====
// ----------------------------------------------------------------------------
// pcs_checker
// port-level checks of the preference cursor selector
// ----------------------------------------------------------------------------
module pcs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid_i,
  input logic                        s_axis_tready_o,
  input logic                        m_axis_tvalid_o,
  input logic                        m_axis_tready_i,
  input logic [pcs_pkg::OutW-1:0]    m_axis_tdata_o
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // end result carries end codes
  a_end_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[14] |->
      m_axis_tdata_o[6:0] == 7'h7F && m_axis_tdata_o[27:15] == 13'd0)
    else $error("end result with nonzero agent or cost");

  // entry result has nonnegative group and position
  a_entry_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[14] |->
      !m_axis_tdata_o[6] && !m_axis_tdata_o[13])
    else $error("entry result with negative cursor");

  // no input taken while a result is stalled
  a_no_accept_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input ready while result stalled");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("ready right after a transfer");

endmodule

bind preference_cursor_selector pcs_checker u_pcs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
